>>> rtl/core/vlcp_pkg.sv
// shared types for the variable length code packer
`default_nettype none
package vlcp_pkg;

  localparam int unsigned CodeBits  = 32;
  localparam int unsigned LenBits   = 6;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned PendBits  = 7;
  localparam int unsigned AccBits   = PendBits + CodeBits;
  localparam int unsigned TotalBits = 6;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } vlcp_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } vlcp_cmd_t;

  typedef struct packed {
    logic has_byte;
    logic out_free;
  } vlcp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/variable_length_code_packer_core.sv
// top level of the msb first variable length code packer
// a request is loaded into the accumulator, its bytes then leave through the output register
// a new request is taken only after all bytes it produces (0 to 5) are emitted; the emit
// loop sends one byte per cycle through the output register while the output does not stall
// reset: synchronous, clears pending bit count, flush flag and output valid
`default_nettype none
module variable_length_code_packer_core #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,  // code_bits[31:0], code_length[37:32], zero pad
  input  wire         s_axis_tlast,  // end_of_stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast   // last_of_run
);
  import vlcp_pkg::*;

  localparam int unsigned CodeCap = (MAX_CODE_LEN < CodeBits) ? MAX_CODE_LEN : CodeBits;

  vlcp_cmd_t    cmd;
  vlcp_status_t status;

  vlcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vlcp_dp #(
    .CODE_CAP (CodeCap)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .code_bits     (s_axis_tdata[31:0]),
    .code_length   (s_axis_tdata[37:32]),
    .end_of_stream (s_axis_tlast),
    .out_byte      (m_axis_tdata),
    .last_of_run   (m_axis_tlast),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready)
  );

endmodule
`default_nettype wire

>>> rtl/core/vlcp_ctrl.sv
// controller state machine for the code packer
`default_nettype none
module vlcp_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_ready,
  input  vlcp_pkg::vlcp_status_t status,
  output vlcp_pkg::vlcp_cmd_t    cmd
);
  import vlcp_pkg::*;

  vlcp_state_t state;
  vlcp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.has_byte) begin
          cmd.emit = status.out_free;
        end else begin
          req_ready = 1'b1;
          if (req_valid) begin
            cmd.load = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/vlcp_dp.sv
// bit accumulator and output register for the code packer
`default_nettype none
module vlcp_dp #(
  parameter int unsigned CODE_CAP = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  vlcp_pkg::vlcp_cmd_t              cmd,
  output vlcp_pkg::vlcp_status_t           status,
  input  wire [vlcp_pkg::CodeBits-1:0]     code_bits,
  input  wire [vlcp_pkg::LenBits-1:0]      code_length,
  input  wire                              end_of_stream,
  output logic [vlcp_pkg::ByteBits-1:0]    out_byte,
  output logic                             last_of_run,
  output logic                             out_valid,
  input  wire                              out_ready
);
  import vlcp_pkg::*;

  localparam logic [LenBits-1:0] Cap = LenBits'(CODE_CAP);

  logic [AccBits-1:0]   acc;
  logic [TotalBits-1:0] total;
  logic                 flush;

  logic [LenBits-1:0]   len_eff;
  logic [CodeBits-1:0]  code_masked;
  logic [PendBits-1:0]  pend;
  logic [AccBits-1:0]   acc_load;
  logic                 full;
  logic                 pad;
  logic [TotalBits-1:0] rem;
  logic [ByteBits-1:0]  full_byte;
  logic [ByteBits-1:0]  pad_byte;
  logic [3:0]           pad_shift;
  logic                 full_last;

  always_comb begin
    len_eff     = (code_length > Cap) ? Cap : code_length;
    code_masked = code_bits & ~({CodeBits{1'b1}} << len_eff);
    pend        = acc[PendBits-1:0] & ~({PendBits{1'b1}} << total[2:0]);
    acc_load    = (AccBits'(pend) << len_eff) | AccBits'(code_masked);
    full        = (total >= TotalBits'(ByteBits));
    pad         = flush && (total != '0) && !full;
    rem         = total - TotalBits'(ByteBits);
    full_byte   = ByteBits'(acc >> rem);
    pad_shift   = 4'(ByteBits) - {1'b0, total[2:0]};
    pad_byte    = acc[ByteBits-1:0] << pad_shift;
    full_last   = (rem < TotalBits'(ByteBits)) && !(flush && (rem != '0));
  end

  assign status.has_byte = full || pad;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      flush <= 1'b0;
    end else if (cmd.load) begin
      total <= {3'b000, total[2:0]} + TotalBits'(len_eff);
      flush <= end_of_stream;
    end else if (cmd.emit) begin
      total <= full ? rem : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= acc_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= full ? full_byte : pad_byte;
      last_of_run <= full ? full_last : 1'b1;
    end
  end

endmodule
`default_nettype wire
